@@ rtl/xowm_pkg.sv @@
// Shared types, constants and opcode helpers for the x86 operand wildcard masker.
package xowm_pkg;

    localparam int WinDepth = 6;
    localparam int ByteW    = 8;

    localparam logic [7:0] OpCallRel  = 8'hE8;
    localparam logic [7:0] OpJmpRel   = 8'hE9;
    localparam logic [7:0] OpTwoByte  = 8'h0F;
    localparam logic [3:0] OpJccHigh  = 4'h8;
    localparam logic [7:0] OpGroup5   = 8'hFF;
    localparam logic [7:0] ModCallRip = 8'h15;
    localparam logic [7:0] ModJmpRip  = 8'h25;
    localparam logic [7:0] ModRmSel   = 8'hC7;
    localparam logic [7:0] ModRmRip   = 8'h05;
    localparam logic [7:0] RexWLow    = 8'h48;
    localparam logic [7:0] RexWHigh   = 8'h4F;

    localparam logic [7:0] OpMovLoad  = 8'h8B;
    localparam logic [7:0] OpMovStore = 8'h89;
    localparam logic [7:0] OpLea      = 8'h8D;
    localparam logic [7:0] OpMovsxd   = 8'h63;
    localparam logic [7:0] OpCmpStore = 8'h39;
    localparam logic [7:0] OpCmpLoad  = 8'h3B;
    localparam logic [7:0] OpXorStore = 8'h31;
    localparam logic [7:0] OpXorLoad  = 8'h33;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       end_of_code;
    } code_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       wildcard_res;
        logic       final_out;
    } res_item_t;

    typedef logic [WinDepth-1:0][ByteW-1:0] win_bytes_t;
    typedef logic [WinDepth-1:0]            win_masks_t;

    typedef struct packed {
        win_masks_t masks;
        logic [2:0] skip;
    } scan_res_t;

    function automatic logic rip_opcode(input logic [7:0] b);
        logic hit;
        hit = (b >= RexWLow && b <= RexWHigh) || (b == OpTwoByte);
        case (b)
            OpMovLoad, OpMovStore, OpLea, OpMovsxd,
            OpCmpStore, OpCmpLoad, OpXorStore, OpXorLoad: hit = 1'b1;
            default: ;
        endcase
        return hit;
    endfunction

endpackage

@@ rtl/xowm_scan.sv @@
// Scan rules for the oldest window position: operand masks and skip count.
module xowm_scan
    import xowm_pkg::*;
(
    input  win_bytes_t bytes,
    input  win_masks_t masks,
    input  logic [2:0] avail,
    input  logic [2:0] skip,
    output scan_res_t  res
);

    localparam win_masks_t NearMask = win_masks_t'(6'b011110);
    localparam win_masks_t FarMask  = win_masks_t'(6'b111100);

    logic [7:0] b;
    logic [7:0] n1;
    logic       full_win;

    assign b        = bytes[0];
    assign n1       = bytes[1];
    assign full_win = (avail == 3'(WinDepth));

    always_comb
    begin
        res.masks = masks;
        res.skip  = skip;
        if (skip != 3'd0)
        begin
            res.skip = skip - 3'd1;
        end
        else if ((b == OpCallRel || b == OpJmpRel) && avail >= 3'd5)
        begin
            res.masks = masks | NearMask;
            res.skip  = 3'd4;
        end
        else if (b == OpTwoByte && full_win && n1[7:4] == OpJccHigh)
        begin
            res.masks = masks | FarMask;
            res.skip  = 3'd5;
        end
        else if (b == OpGroup5 && full_win && (n1 == ModCallRip || n1 == ModJmpRip))
        begin
            res.masks = masks | FarMask;
            res.skip  = 3'd5;
        end
        else if (full_win && (n1 & ModRmSel) == ModRmRip && rip_opcode(b))
        begin
            res.masks = masks | FarMask;
        end
    end

endmodule

@@ rtl/x86_operand_wildcard_masker.sv @@
// Top level: six-byte scan window, end-of-code flush and result register.
// Outside a flush, a byte leaves in the cycle after the byte five places behind it is accepted.
// Throughput: one byte per cycle; the end mark starts a flush of the pending bytes (1..6), which stalls input.
// The single result register sets the rate: input stalls while it holds an untaken result.
// Reset (rst_n low, asynchronous) empties the window and the result register.
module x86_operand_wildcard_masker
    import xowm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       code_valid,
    output logic       code_ready,
    input  code_item_t code_data,
    output logic       res_valid,
    input  logic       res_ready,
    output res_item_t  res_data
);

    win_bytes_t bytes_reg, bytes_next;
    win_masks_t masks_reg, masks_next;
    logic [2:0] fill_reg, fill_next;
    logic [2:0] skip_reg, skip_next;
    logic       flush_reg, flush_next;
    logic       res_valid_reg, res_valid_next;
    res_item_t  res_data_reg, res_data_next;

    win_bytes_t view_bytes;
    win_masks_t view_masks;
    logic [2:0] view_avail;
    scan_res_t  scan;
    logic       slot_free;
    logic       code_fire;

    assign slot_free  = !res_valid_reg || res_ready;
    assign code_ready = !flush_reg && slot_free;
    assign code_fire  = code_valid && code_ready;
    assign res_valid  = res_valid_reg;
    assign res_data   = res_data_reg;

    always_comb
    begin
        view_bytes = bytes_reg;
        view_masks = masks_reg;
        view_avail = fill_reg;
        if (!flush_reg)
        begin
            view_bytes[WinDepth-1] = code_data.code_byte;
            view_masks[WinDepth-1] = 1'b0;
            view_avail             = 3'(WinDepth);
        end
    end

    xowm_scan u_scan (
        .bytes (view_bytes),
        .masks (view_masks),
        .avail (view_avail),
        .skip  (skip_reg),
        .res   (scan)
    );

    always_comb
    begin
        bytes_next     = bytes_reg;
        masks_next     = masks_reg;
        fill_next      = fill_reg;
        skip_next      = skip_reg;
        flush_next     = flush_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_data_next  = res_data_reg;
        if (flush_reg)
        begin
            if (slot_free)
            begin
                res_valid_next             = 1'b1;
                res_data_next.out_byte     = view_bytes[0];
                res_data_next.wildcard_res = view_masks[0];
                res_data_next.final_out    = (fill_reg == 3'd1);
                bytes_next = win_bytes_t'(view_bytes >> ByteW);
                masks_next = win_masks_t'(scan.masks >> 1);
                skip_next  = scan.skip;
                fill_next  = fill_reg - 3'd1;
                if (fill_reg == 3'd1)
                begin
                    bytes_next = '0;
                    masks_next = '0;
                    skip_next  = 3'd0;
                    flush_next = 1'b0;
                end
            end
        end
        else if (code_fire)
        begin
            if (code_data.end_of_code)
            begin
                bytes_next[fill_reg] = code_data.code_byte;
                masks_next[fill_reg] = 1'b0;
                fill_next            = fill_reg + 3'd1;
                flush_next           = 1'b1;
            end
            else if (fill_reg == 3'(WinDepth - 1))
            begin
                res_valid_next             = 1'b1;
                res_data_next.out_byte     = view_bytes[0];
                res_data_next.wildcard_res = view_masks[0];
                res_data_next.final_out    = 1'b0;
                bytes_next = win_bytes_t'(view_bytes >> ByteW);
                masks_next = win_masks_t'(scan.masks >> 1);
                skip_next  = scan.skip;
            end
            else
            begin
                bytes_next[fill_reg] = code_data.code_byte;
                masks_next[fill_reg] = 1'b0;
                fill_next            = fill_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg     <= '0;
            masks_reg     <= '0;
            fill_reg      <= 3'd0;
            skip_reg      <= 3'd0;
            flush_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            bytes_reg     <= bytes_next;
            masks_reg     <= masks_next;
            fill_reg      <= fill_next;
            skip_reg      <= skip_next;
            flush_reg     <= flush_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !flush_reg |-> fill_reg <= 3'(WinDepth - 1))
        else $error("window fill exceeds depth outside flush");

    a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        flush_reg |-> fill_reg != 3'd0)
        else $error("flush with empty window");

    a_flush_end: assert property (@(posedge clk) disable iff (!rst_n)
        (flush_reg && slot_free && fill_reg == 3'd1) |=>
            (!flush_reg && fill_reg == 3'd0 && skip_reg == 3'd0 && res_data_reg.final_out))
        else $error("flush did not close the transaction stream cleanly");

    a_skip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg <= 3'd5)
        else $error("skip count out of range");
`endif

endmodule

@@ tb/sv/x86_operand_wildcard_masker_tb.sv @@
// Testbench for the x86 operand wildcard masker: directed and random prologues, scoreboard check.
module x86_operand_wildcard_masker_tb
    import xowm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] OpRet      = 8'hC3;

    logic       clk;
    logic       rst_n;
    logic       code_valid;
    logic       code_ready;
    code_item_t code_data;
    logic       res_valid;
    logic       res_ready;
    res_item_t  res_data;

    logic [7:0]  win_byte [WinDepth];
    logic        win_mask [WinDepth];
    int unsigned win_fill;
    int unsigned skip_count;
    res_item_t   expected_bytes[$];

    logic [7:0]  code_seq[$];
    bit          no_idle;
    int unsigned mismatches;
    int unsigned bytes_sent;
    int unsigned prologues_sent;
    int unsigned results_checked;
    int unsigned wildcards_seen;

    x86_operand_wildcard_masker u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_valid (code_valid),
        .code_ready (code_ready),
        .code_data  (code_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("timeout with %0d results still pending", expected_bytes.size());
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic bit is_rip_addr_op(input logic [7:0] b);
        return (b >= RexWLow && b <= RexWHigh) || b == OpTwoByte ||
               b inside {OpMovLoad, OpMovStore, OpLea, OpMovsxd,
                         OpCmpStore, OpCmpLoad, OpXorStore, OpXorLoad};
    endfunction

    function automatic void mark_wildcards(input int unsigned from);
        for (int unsigned j = from; j < from + 4 && j < WinDepth; j++)
            win_mask[j] = 1'b1;
    endfunction

    function automatic void scan_oldest_byte(input int unsigned avail);
        logic [7:0] b;
        logic [7:0] n1;
        b  = win_byte[0];
        n1 = win_byte[1];
        if (skip_count > 0)
            skip_count--;
        else if ((b == OpCallRel || b == OpJmpRel) && avail >= 5)
        begin
            mark_wildcards(1);
            skip_count = 4;
        end
        else if (b == OpTwoByte && avail >= 6 && n1[7:4] == OpJccHigh)
        begin
            mark_wildcards(2);
            skip_count = 5;
        end
        else if (b == OpGroup5 && avail >= 6 && (n1 == ModCallRip || n1 == ModJmpRip))
        begin
            mark_wildcards(2);
            skip_count = 5;
        end
        else if (avail >= 6 && (n1 & ModRmSel) == ModRmRip && is_rip_addr_op(b))
            mark_wildcards(2);
    endfunction

    function automatic void emit_oldest_byte(input bit last);
        res_item_t r;
        r.out_byte     = win_byte[0];
        r.wildcard_res = win_mask[0];
        r.final_out    = last;
        expected_bytes = {expected_bytes, r};
        for (int j = 0; j < WinDepth - 1; j++)
        begin
            win_byte[j] = win_byte[j + 1];
            win_mask[j] = win_mask[j + 1];
        end
        win_byte[WinDepth - 1] = '0;
        win_mask[WinDepth - 1] = 1'b0;
        if (win_fill > 0)
            win_fill--;
    endfunction

    function automatic void clear_window();
        for (int j = 0; j < WinDepth; j++)
        begin
            win_byte[j] = '0;
            win_mask[j] = 1'b0;
        end
        win_fill   = 0;
        skip_count = 0;
    endfunction

    function automatic void predict_wildcards(input code_item_t it);
        if (win_fill >= WinDepth)
            win_fill = WinDepth - 1;
        win_byte[win_fill] = it.code_byte;
        win_mask[win_fill] = 1'b0;
        win_fill++;
        if (!it.end_of_code)
        begin
            if (win_fill == WinDepth)
            begin
                scan_oldest_byte(WinDepth);
                emit_oldest_byte(1'b0);
            end
        end
        else
        begin
            while (win_fill > 0)
            begin
                scan_oldest_byte(win_fill);
                emit_oldest_byte(win_fill == 1);
            end
            clear_window();
        end
    endfunction

    function automatic void append_code(input logic [7:0] b);
        code_seq = {code_seq, b};
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
        mismatches++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eoc);
        @(negedge clk);
        while (!no_idle && $urandom_range(99, 0) < 15)
        begin
            code_valid = 1'b0;
            @(negedge clk);
        end
        code_data  = {b, eoc};
        code_valid = 1'b1;
        do
            @(posedge clk);
        while (!code_ready);
        predict_wildcards(code_data);
        bytes_sent++;
        if (eoc)
            prologues_sent++;
    endtask

    task automatic send_prologue();
        foreach (code_seq[i])
            send_byte(code_seq[i], i == code_seq.size() - 1);
    endtask

    initial
    begin
        res_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_ready = no_idle || ($urandom_range(99, 0) >= 15);
        end
    end

    always @(posedge clk)
    begin : result_check
        res_item_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_bytes.size() == 0)
                report_mismatch("unexpected result byte", 0, 32'(res_data.out_byte));
            else
            begin
                want = expected_bytes.pop_front();
                if (res_data.out_byte !== want.out_byte)
                    report_mismatch("out_byte", 32'(want.out_byte), 32'(res_data.out_byte));
                if (res_data.wildcard_res !== want.wildcard_res)
                    report_mismatch("wildcard_res", 32'(want.wildcard_res),
                                    32'(res_data.wildcard_res));
                if (res_data.final_out !== want.final_out)
                    report_mismatch("final_out", 32'(want.final_out), 32'(res_data.final_out));
                results_checked++;
                if (want.wildcard_res)
                    wildcards_seen++;
            end
        end
    end

    task automatic test_lone_byte();
        code_seq = {OpRet};
        send_prologue();
    endtask

    task automatic test_rel_branches();
        code_seq = {OpCallRel, 8'h00, 8'h00, 8'h00, 8'h80, OpJmpRel, 8'hFF, 8'hFF};
        send_prologue();
    endtask

    task automatic test_jcc_indirect();
        code_seq = {OpTwoByte, 8'h80, 8'h01, 8'h02, 8'h03, 8'h04,
                    OpGroup5, ModJmpRip, 8'h05, 8'h06, 8'h07};
        send_prologue();
    endtask

    task automatic test_rip_relative();
        code_seq = {RexWLow, OpLea, ModRmRip, OpCallRel, 8'h11, 8'h22, 8'h33, 8'h44};
        send_prologue();
    endtask

    task automatic build_prologue(input bit noisy);
        int unsigned target;
        logic [7:0]  pick;
        target   = ($urandom_range(9, 0) == 0) ? $urandom_range(5, 1) : $urandom_range(24, 6);
        code_seq = {};
        while (code_seq.size() < target)
        begin
            if (noisy)
                append_code(8'($urandom_range(255, 0)));
            else
            begin
                case ($urandom_range(5, 0))
                    0:
                    begin
                        append_code($urandom_range(1, 0) ? OpCallRel : OpJmpRel);
                        repeat (4) append_code(8'($urandom_range(255, 0)));
                    end
                    1:
                    begin
                        append_code(OpTwoByte);
                        append_code({OpJccHigh, 4'($urandom_range(15, 0))});
                        repeat (4) append_code(8'($urandom_range(255, 0)));
                    end
                    2:
                    begin
                        append_code(OpGroup5);
                        append_code($urandom_range(1, 0) ? ModCallRip : ModJmpRip);
                        repeat (4) append_code(8'($urandom_range(255, 0)));
                    end
                    3:
                    begin
                        case ($urandom_range(10, 0))
                            0: pick = OpMovLoad;
                            1: pick = OpMovStore;
                            2: pick = OpLea;
                            3: pick = OpMovsxd;
                            4: pick = OpCmpStore;
                            5: pick = OpCmpLoad;
                            6: pick = OpXorStore;
                            7: pick = OpXorLoad;
                            8: pick = OpTwoByte;
                            default: pick = RexWLow + 8'($urandom_range(7, 0));
                        endcase
                        append_code(pick);
                        if ($urandom_range(3, 0) == 0)
                            append_code(8'($urandom_range(255, 0)));
                        else
                            append_code({2'b00, 3'($urandom_range(7, 0)), 3'b101});
                        repeat (4) append_code(8'($urandom_range(255, 0)));
                    end
                    default: append_code(8'($urandom_range(255, 0)));
                endcase
            end
        end
        while (code_seq.size() > target)
            void'(code_seq.pop_back());
    endtask

    task automatic test_random_prologues(input int unsigned n_bytes);
        int unsigned stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            build_prologue($urandom_range(99, 0) < 15);
            send_prologue();
        end
    endtask

    task automatic test_back_to_back(input int unsigned n_bytes);
        no_idle = 1'b1;
        test_random_prologues(n_bytes);
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        code_valid      = 1'b0;
        code_data       = '0;
        no_idle         = 1'b0;
        mismatches      = 0;
        bytes_sent      = 0;
        prologues_sent  = 0;
        results_checked = 0;
        wildcards_seen  = 0;
        clear_window();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_lone_byte();
        test_rel_branches();
        test_jcc_indirect();
        test_rip_relative();
        test_random_prologues(100);
        test_back_to_back(70);
        test_random_prologues(50);

        @(negedge clk);
        code_valid = 1'b0;
        for (int i = 0; i < 5000 && expected_bytes.size() > 0; i++)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (expected_bytes.size() > 0)
            report_mismatch("results never delivered", unsigned'(expected_bytes.size()), 0);

        $display("sent %0d code bytes in %0d prologues", bytes_sent, prologues_sent);
        $display("checked %0d result bytes, %0d of them wildcards, %0d mismatches",
                 results_checked, wildcards_seen, mismatches);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
